>>> src/brle_pkg.sv
// Shared types and constants for the blocked escape run-length decoder.
`default_nettype none

package brle_pkg;

  localparam int unsigned CfgWidth          = 24;
  localparam int unsigned BudgetBitsDefault = 24;
  localparam logic [CfgWidth-1:0] PixelBudgetReset = 24'd64000;
  localparam int unsigned HeaderLen         = 5;
  localparam logic [2:0]  HdrLastIdx        = 3'd4;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StClip  = 2'd1;
  localparam logic [1:0] StError = 2'd2;

  typedef enum logic [3:0] {
    PhCntLo,
    PhCntHi,
    PhToken,
    PhEscCnt,
    PhEscVal,
    PhLongLo,
    PhLongHi,
    PhLongVal,
    PhDone
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  run_value;
    logic [15:0] run_length;
    logic        image_done;
    logic [1:0]  status;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/blocked_escape_rle_decoder.sv
// Top level: blocked escape run-length decoder with output skid register.
`default_nettype none

// Decodes a blocked escape-coded byte stream (16-bit block count, 5-byte block
// headers, escape byte with short or long count) into value/length runs clipped
// to the configured pixel budget. One stream byte is accepted every cycle while
// in_stall_o is low; the parse state updates in the accept cycle and its result
// is registered in the output register or, under back-pressure, in a one-entry
// skid register, so input stall rises only when both the output and skid
// registers hold results. Write pixel_budget only while the decoder is idle.
module blocked_escape_rle_decoder #(
  parameter int unsigned BUDGET_BITS = brle_pkg::BudgetBitsDefault
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  brle_pkg::in_item_t            in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output brle_pkg::out_item_t                 out_data_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [brle_pkg::CfgWidth-1:0]       cfg_data_i
);
  import brle_pkg::*;

  localparam logic [15:0] HdrLen16 = 16'(HeaderLen);

  logic [CfgWidth-1:0]    pixel_budget_q;
  phase_e                 phase_q, phase_d;
  logic [15:0]            blocks_q, blocks_d;
  logic [15:0]            bleft_q, bleft_d;
  logic [2:0]             hdr_idx_q, hdr_idx_d;
  logic [7:0]             esc_q, esc_d;
  logic [15:0]            count_q, count_d;
  logic [BUDGET_BITS-1:0] budget_q, budget_d;
  logic [7:0]             len_lo_q, len_lo_d;

  out_item_t out_q, skid_q, res;
  logic      out_valid_q, skid_valid_q;
  logic      res_valid;
  logic      in_acc, pop, push;

  // Working copies after an optional start-of-image clear.
  phase_e                 ph_s;
  logic [15:0]            blocks_s, bleft_s, count_s, bl_dec, len16;
  logic [2:0]             hdr_s;
  logic [7:0]             esc_s, len_lo_s, b;
  logic [BUDGET_BITS-1:0] budget_s, budget_new;
  logic [15:0]            run_r, run_len;
  logic                   do_run, do_check, do_fail, clip, ended;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign pop         = out_valid_q & ~out_stall_i;
  assign push        = in_acc & res_valid;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    b = in_data_i.in_byte;
    if (in_data_i.start_image) begin
      ph_s     = PhCntLo;
      blocks_s = '0;
      bleft_s  = '0;
      hdr_s    = '0;
      esc_s    = '0;
      count_s  = '0;
      len_lo_s = '0;
      budget_s = BUDGET_BITS'(pixel_budget_q);
    end else begin
      ph_s     = phase_q;
      blocks_s = blocks_q;
      bleft_s  = bleft_q;
      hdr_s    = hdr_idx_q;
      esc_s    = esc_q;
      count_s  = count_q;
      len_lo_s = len_lo_q;
      budget_s = budget_q;
    end

    phase_d   = ph_s;
    blocks_d  = blocks_s;
    bleft_d   = bleft_s;
    hdr_idx_d = hdr_s;
    esc_d     = esc_s;
    count_d   = count_s;
    len_lo_d  = len_lo_s;
    budget_d  = budget_s;

    do_run   = 1'b0;
    do_check = 1'b0;
    do_fail  = 1'b0;
    run_r    = '0;
    bl_dec   = bleft_s - 16'd1;
    len16    = {b, len_lo_s};

    case (ph_s)
      PhDone: ;
      PhCntLo: begin
        blocks_d = {8'd0, b};
        phase_d  = PhCntHi;
      end
      PhCntHi: begin
        blocks_d = {b, blocks_s[7:0]};
        phase_d  = PhToken;
        do_check = 1'b1;
      end
      default: begin
        if (hdr_s != 3'd0 || bleft_s == 16'd0) begin
          // Block header byte
          if (hdr_s == 3'd0 && blocks_s == 16'd0) begin
            do_fail = 1'b1;
          end else begin
            case (hdr_s)
              3'd0: begin
                len_lo_d  = b;
                hdr_idx_d = 3'd1;
              end
              3'd1: begin
                bleft_d   = (len16 > HdrLen16) ? len16 - HdrLen16 : 16'd0;
                hdr_idx_d = 3'd2;
              end
              3'd2, 3'd3: hdr_idx_d = hdr_s + 3'd1;
              default: begin
                esc_d     = b;
                hdr_idx_d = 3'd0;
                blocks_d  = blocks_s - 16'd1;
                if (ph_s == PhLongLo) begin
                  do_fail = (bleft_s < 16'd3);
                end else begin
                  do_fail = (bleft_s == 16'd0);
                end
              end
            endcase
          end
        end else begin
          bleft_d = bl_dec;
          case (ph_s)
            PhToken: begin
              if (b != esc_s) begin
                do_run = 1'b1;
                run_r  = 16'd1;
              end else begin
                phase_d  = PhEscCnt;
                do_check = 1'b1;
              end
            end
            PhEscCnt: begin
              if (b != 8'd0) begin
                count_d  = {8'd0, b};
                phase_d  = PhEscVal;
                do_check = 1'b1;
              end else begin
                phase_d = PhLongLo;
                // long form must not straddle a block boundary
                if (bl_dec == 16'd1 || bl_dec == 16'd2) begin
                  do_fail = 1'b1;
                end else begin
                  do_check = 1'b1;
                end
              end
            end
            PhEscVal: begin
              do_run = 1'b1;
              run_r  = count_s;
            end
            PhLongLo: begin
              count_d  = {8'd0, b};
              phase_d  = PhLongHi;
              do_check = 1'b1;
            end
            PhLongHi: begin
              count_d  = {b, count_s[7:0]};
              phase_d  = PhLongVal;
              do_check = 1'b1;
            end
            PhLongVal: begin
              do_run = 1'b1;
              run_r  = count_s;
            end
            default: do_fail = 1'b1;
          endcase
        end
      end
    endcase

    ended = (hdr_idx_d == 3'd0) && (bleft_d == 16'd0) && (blocks_d == 16'd0);

    // Clip the run to what is left of the budget.
    clip       = BUDGET_BITS'(run_r) > budget_s;
    run_len    = clip ? budget_s[15:0] : run_r;
    budget_new = budget_s - BUDGET_BITS'(run_len);

    res       = '0;
    res_valid = 1'b0;
    if (do_fail) begin
      phase_d        = PhDone;
      res.image_done = 1'b1;
      res.status     = StError;
      res_valid      = 1'b1;
    end else if (do_run) begin
      budget_d       = budget_new;
      res.run_value  = b;
      res.run_length = run_len;
      res.status     = clip ? StClip : StOk;
      res.image_done = (budget_new == '0) || ended;
      phase_d        = res.image_done ? PhDone : PhToken;
      res_valid      = 1'b1;
    end else if (do_check && ended) begin
      res.image_done = 1'b1;
      res.status     = (phase_d == PhToken) ? StOk : StError;
      phase_d        = PhDone;
      res_valid      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_budget_q <= PixelBudgetReset;
      phase_q        <= PhCntLo;
      blocks_q       <= '0;
      bleft_q        <= '0;
      hdr_idx_q      <= '0;
      esc_q          <= '0;
      count_q        <= '0;
      budget_q       <= '0;
      len_lo_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        pixel_budget_q <= cfg_data_i;
      end
      if (in_acc) begin
        phase_q   <= phase_d;
        blocks_q  <= blocks_d;
        bleft_q   <= bleft_d;
        hdr_idx_q <= hdr_idx_d;
        esc_q     <= esc_d;
        count_q   <= count_d;
        budget_q  <= budget_d;
        len_lo_q  <= len_lo_d;
      end
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      out_valid_q  <= skid_valid_q | push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDone && !(in_acc && in_data_i.start_image)) |=> phase_q == PhDone)
    else $error("left done state without start of image");

  a_hdr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_idx_q <= HdrLastIdx)
    else $error("header index out of range");

  a_clip_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res.status == StClip) |-> res.image_done)
    else $error("clipped run without image done");

  a_no_result_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PhDone && !in_data_i.start_image) |-> !res_valid)
    else $error("result produced after image done");
`endif

endmodule

`default_nettype wire
